// File: hdl/calendar_clock_second_step_core_assert.svh
// ----------------------------------------------------------------------------
// calendar_clock_second_step_core_assert
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef CALENDAR_CLOCK_SECOND_STEP_CORE_ASSERT_SVH
`define CALENDAR_CLOCK_SECOND_STEP_CORE_ASSERT_SVH

// property must hold at every clock edge outside reset
`define CCSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true outside reset
`define CCSS_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// File: hdl/ccss_pkg.sv
// ----------------------------------------------------------------------------
// ccss_pkg
// field widths, stage types and the month length table of the one-second step
// ----------------------------------------------------------------------------
package ccss_pkg;

  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int YearW   = 14;
  localparam int HourW   = 5;
  localparam int MinuteW = 6;
  localparam int SecondW = 6;

  // year / 25 by reciprocal: floor(y * Recip25 / 2^Recip25Sh), exact below 2^14
  localparam int Recip25Sh = 20;
  localparam int Recip25   = (1 << Recip25Sh) / 25 + 1;
  localparam int RecipW    = 16;
  localparam int ProdW     = YearW + RecipW;
  localparam int QuotW     = ProdW - Recip25Sh;

  localparam logic [MonthW-1:0]  MonthJan  = 4'd1;
  localparam logic [MonthW-1:0]  MonthFeb  = 4'd2;
  localparam logic [MonthW-1:0]  MonthDec  = 4'd12;
  localparam logic [DayW-1:0]    DayFirst  = 5'd1;
  localparam logic [YearW-1:0]   YearLast  = 14'd9999;
  localparam logic [HourW-1:0]   HourLast  = 5'd23;
  localparam logic [MinuteW-1:0] MinuteLast = 6'd59;
  localparam logic [SecondW-1:0] SecondLast = 6'd59;

  typedef struct packed {
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [YearW-1:0]   year;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } stamp_t;

  // carry chain flags worked out in the second stage
  typedef struct packed {
    logic bad;
    logic sec_wrap;
    logic min_wrap;
    logic hour_wrap;
    logic month_end;
    logic year_end;
    logic last_year;
  } carry_t;

  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] month,
                                                 input logic leap);
    logic [DayW-1:0] len;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MonthFeb:                                   len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: hdl/calendar_clock_second_step_core.sv
// ----------------------------------------------------------------------------
// calendar_clock_second_step_core
// advances a gregorian date and 24-hour time by one second
// ----------------------------------------------------------------------------
// usage
//   a request (month, day, year, hour, minute, second) is taken at the rising
//   edge where start is high and busy is low; busy is always low, so a new
//   request may be given in every cycle
//   the result shows on the out_* ports together with valid_o for exactly one
//   cycle, once the request has passed the stage 1, 2 and 3 registers, and is
//   taken at the edge that ends that cycle; results come back in request order, one per request
//   throughput is one request per cycle; a request passes through the
//   three register stages: operand capture with the year / 25 product, leap
//   year, month length and carry flags, then the final increment
//   input_invalid_o flags a field out of range or a day past the month end;
//   the date and time are then returned unchanged
//   reset clears the stage valid bits only, so nothing is in flight after it
//   the receiver cannot hold results off, so the pipeline never stalls
// ----------------------------------------------------------------------------
module calendar_clock_second_step_core
  import ccss_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [MonthW-1:0]  in_month_i,
  input  logic [DayW-1:0]    in_day_i,
  input  logic [YearW-1:0]   in_year_i,
  input  logic [HourW-1:0]   in_hour_i,
  input  logic [MinuteW-1:0] in_minute_i,
  input  logic [SecondW-1:0] in_second_i,
  output logic               valid_o,
  output logic [MonthW-1:0]  out_month_o,
  output logic [DayW-1:0]    out_day_o,
  output logic [YearW-1:0]   out_year_o,
  output logic [HourW-1:0]   out_hour_o,
  output logic [MinuteW-1:0] out_minute_o,
  output logic [SecondW-1:0] out_second_o,
  output logic               input_invalid_o
);

  // ---- stage 1: capture request, start year / 25 -------------------------
  logic             s1_valid_q;
  stamp_t           s1_stamp_q;
  logic [ProdW-1:0] s1_prod_q;
  logic             accept;

  // pipeline always moves, so a request is never refused
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  // payload needs no reset, only the valid bit does
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_stamp_q <= '{month: in_month_i, day: in_day_i, year: in_year_i,
                      hour: in_hour_i, minute: in_minute_i, second: in_second_i};
      s1_prod_q  <= ProdW'(in_year_i) * ProdW'(Recip25);
    end
  end

  // ---- stage 2: leap year, month length, range checks, carry flags --------
  logic [QuotW-1:0] s2_quot;
  logic [YearW-1:0] s2_quot25;
  logic             s2_div25;
  logic             s2_leap;
  logic [DayW-1:0]  s2_mlen;
  carry_t           s2_carry_d;
  carry_t           s2_carry_q;
  stamp_t           s2_stamp_q;
  logic             s2_valid_q;

  always_comb begin
    s2_quot   = s1_prod_q[ProdW-1:Recip25Sh];
    // q * 25 as shift and add
    s2_quot25 = YearW'({s2_quot, 4'b0}) + YearW'({s2_quot, 3'b0}) + YearW'(s2_quot);
    s2_div25  = (s2_quot25 == s1_stamp_q.year);
    // divisible by 4 and either not by 100 or also by 400 (16 * 25)
    s2_leap   = (s1_stamp_q.year[1:0] == 2'b00)
                && (!s2_div25 || (s1_stamp_q.year[3:0] == 4'b0000));
    s2_mlen   = month_days(s1_stamp_q.month, s2_leap);

    s2_carry_d.bad       = (s1_stamp_q.month < MonthJan) || (s1_stamp_q.month > MonthDec)
                           || (s1_stamp_q.year > YearLast) || (s1_stamp_q.hour > HourLast)
                           || (s1_stamp_q.minute > MinuteLast)
                           || (s1_stamp_q.second > SecondLast)
                           || (s1_stamp_q.day < DayFirst) || (s1_stamp_q.day > s2_mlen);
    s2_carry_d.sec_wrap  = (s1_stamp_q.second == SecondLast);
    s2_carry_d.min_wrap  = (s1_stamp_q.minute == MinuteLast);
    s2_carry_d.hour_wrap = (s1_stamp_q.hour == HourLast);
    s2_carry_d.month_end = (s1_stamp_q.day == s2_mlen);
    s2_carry_d.year_end  = (s1_stamp_q.month == MonthDec);
    s2_carry_d.last_year = (s1_stamp_q.year == YearLast);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_stamp_q <= s1_stamp_q;
      s2_carry_q <= s2_carry_d;
    end
  end

  // ---- stage 3: ripple the increment through the fields -------------------
  stamp_t s3_stamp_d;
  logic   s3_min_step;
  logic   s3_hour_step;
  logic   s3_date_step;
  stamp_t s3_stamp_q;
  logic   s3_bad_q;
  logic   s3_valid_q;

  always_comb begin
    s3_stamp_d   = s2_stamp_q;
    s3_min_step  = s2_carry_q.sec_wrap;
    s3_hour_step = s3_min_step && s2_carry_q.min_wrap;
    s3_date_step = s3_hour_step && s2_carry_q.hour_wrap;

    if (!s2_carry_q.bad) begin
      s3_stamp_d.second = s2_carry_q.sec_wrap ? '0 : s2_stamp_q.second + SecondW'(1);
      if (s3_min_step) begin
        s3_stamp_d.minute = s2_carry_q.min_wrap ? '0 : s2_stamp_q.minute + MinuteW'(1);
      end
      if (s3_hour_step) begin
        s3_stamp_d.hour = s2_carry_q.hour_wrap ? '0 : s2_stamp_q.hour + HourW'(1);
      end
      // midnight: day, then month, then year
      if (s3_date_step) begin
        priority if (!s2_carry_q.month_end) begin
          s3_stamp_d.day = s2_stamp_q.day + DayW'(1);
        end else if (s2_carry_q.year_end) begin
          s3_stamp_d.day   = DayFirst;
          s3_stamp_d.month = MonthJan;
          s3_stamp_d.year  = s2_carry_q.last_year ? '0 : s2_stamp_q.year + YearW'(1);
        end else begin
          s3_stamp_d.day   = DayFirst;
          s3_stamp_d.month = s2_stamp_q.month + MonthW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      s3_stamp_q <= s3_stamp_d;
      s3_bad_q   <= s2_carry_q.bad;
    end
  end

  // ---- result ports ---------------------------------------------------------
  assign valid_o         = s3_valid_q;
  assign out_month_o     = s3_stamp_q.month;
  assign out_day_o       = s3_stamp_q.day;
  assign out_year_o      = s3_stamp_q.year;
  assign out_hour_o      = s3_stamp_q.hour;
  assign out_minute_o    = s3_stamp_q.minute;
  assign out_second_o    = s3_stamp_q.second;
  assign input_invalid_o = s3_bad_q;

endmodule

// File: hdl/ccss_checker.sv
// ----------------------------------------------------------------------------
// ccss_checker
// port level checks of the one-second step core, bound to the top level
// ----------------------------------------------------------------------------
`include "calendar_clock_second_step_core_assert.svh"

module ccss_checker
  import ccss_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic [MonthW-1:0]  in_month_i,
  input logic [DayW-1:0]    in_day_i,
  input logic [YearW-1:0]   in_year_i,
  input logic [HourW-1:0]   in_hour_i,
  input logic [MinuteW-1:0] in_minute_i,
  input logic [SecondW-1:0] in_second_i,
  input logic               valid_o,
  input logic [MonthW-1:0]  out_month_o,
  input logic [DayW-1:0]    out_day_o,
  input logic [YearW-1:0]   out_year_o,
  input logic [HourW-1:0]   out_hour_o,
  input logic [MinuteW-1:0] out_minute_o,
  input logic [SecondW-1:0] out_second_o,
  input logic               input_invalid_o
);

  // every accepted request comes back as a result with valid_o
  `CCSS_ASSERT(a_req_to_result, (start && !busy) |-> ##3 valid_o, "request lost")

  // no result without an earlier accepted request
  `CCSS_ASSERT(a_result_has_req, valid_o |-> $past(start && !busy, 3), "result invented")

  // flagged request passes straight through
  `CCSS_ASSERT(a_invalid_passthru, (valid_o && input_invalid_o) |->
    (out_month_o == $past(in_month_i, 3)) && (out_day_o == $past(in_day_i, 3))
    && (out_year_o == $past(in_year_i, 3)) && (out_hour_o == $past(in_hour_i, 3))
    && (out_minute_o == $past(in_minute_i, 3))
    && (out_second_o == $past(in_second_i, 3)), "invalid request altered")

  // seconds of a good request step by one modulo sixty
  `CCSS_ASSERT(a_second_step, (valid_o && !input_invalid_o) |->
    (out_second_o == (($past(in_second_i, 3) == SecondLast) ? '0
                      : $past(in_second_i, 3) + SecondW'(1))), "second not stepped")

  // a good result never leaves the time ranges
  `CCSS_NEVER(a_time_range, valid_o && !input_invalid_o
    && ((out_hour_o > HourLast) || (out_minute_o > MinuteLast)
        || (out_second_o > SecondLast)), "time out of range")

endmodule

bind calendar_clock_second_step_core ccss_checker u_ccss_checker (.*);
